/* sv/mcts_pkg.sv */
`timescale 1ns / 1ps
package mcts_pkg;

    localparam int MaxSymbols = 16;
    localparam int IdxW       = 4;
    localparam int SizeW      = 5;
    localparam int CodeW      = 16;
    localparam int CountW     = 16;
    localparam int SumW       = 20;
    localparam int RandW      = 16;
    localparam int AddrW      = 2 * IdxW;
    localparam int TargetW    = SumW + RandW;
    localparam int QDepth     = 2;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_TRAIN   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NEXT    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_TRAIN,
        K_RESTART,
        K_NEXT
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_TRAIN_UPD,
        S_WALK
    } t_state;

    typedef struct packed {
        t_kind            kind;
        logic [CodeW-1:0] code;
        logic [RandW-1:0] rv;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [IdxW-1:0]  index;
        logic [CodeW-1:0] code;
        logic             is_new;
        logic [SizeW-1:0] size;
    } t_result;

endpackage

/* sv/mcts_front.sv */
`timescale 1ns / 1ps
module mcts_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_operation,
    input  logic [mcts_pkg::CodeW-1:0] i_symbol_code,
    input  logic [mcts_pkg::RandW-1:0] i_random_value,
    output logic                     o_q_valid,
    output mcts_pkg::t_cmd           o_q_cmd,
    input  logic                     i_q_pop
);

    mcts_pkg::t_cmd r_q [mcts_pkg::QDepth];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    mcts_pkg::t_cmd w_cmd;
    logic       w_push;
    logic       w_pop;

    // classify the incoming transaction
    always_comb begin
        w_cmd.code = i_symbol_code;
        w_cmd.rv   = i_random_value;
        case (i_operation)
            mcts_pkg::OP_CLEAR:   w_cmd.kind = mcts_pkg::K_CLEAR;
            mcts_pkg::OP_TRAIN:   w_cmd.kind = mcts_pkg::K_TRAIN;
            mcts_pkg::OP_RESTART: w_cmd.kind = mcts_pkg::K_RESTART;
            default:              w_cmd.kind = mcts_pkg::K_NEXT;
        endcase
    end

    assign busy      = (r_count == 2'(mcts_pkg::QDepth));
    assign w_push    = start && !busy;
    assign o_q_valid = (r_count != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* sv/mcts_back.sv */
`timescale 1ns / 1ps
module mcts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mcts_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    output mcts_pkg::t_result o_result
);

    localparam int IdxW  = mcts_pkg::IdxW;
    localparam int SizeW = mcts_pkg::SizeW;
    localparam int CodeW = mcts_pkg::CodeW;
    localparam int CntW  = mcts_pkg::CountW;
    localparam int SumW  = mcts_pkg::SumW;
    localparam int AddrW = mcts_pkg::AddrW;
    localparam int TgtW  = mcts_pkg::TargetW;
    localparam int MaxS  = mcts_pkg::MaxSymbols;

    mcts_pkg::t_state r_state, n_state;
    mcts_pkg::t_cmd   r_cmd;

    logic [CodeW-1:0] r_codes [MaxS];
    logic [SizeW-1:0] r_learned, n_learned;
    logic [SumW-1:0]  r_sums [MaxS];
    logic [MaxS*MaxS-1:0] r_vld;
    logic [IdxW-1:0]  r_prev_idx, n_prev_idx;
    logic             r_prev_vld, n_prev_vld;
    logic [IdxW-1:0]  r_chain, n_chain;

    logic [CntW-1:0]  r_mem [MaxS*MaxS];
    logic [CntW-1:0]  r_rd_data;
    logic             r_rd_vld;
    logic [AddrW-1:0] w_rd_addr;

    logic [IdxW-1:0]  r_row, n_row;
    logic [IdxW-1:0]  r_col, n_col;
    logic [SumW-1:0]  r_cum, n_cum;
    logic [TgtW-1:0]  r_target, n_target;

    logic             r_out_valid, n_out_valid;
    mcts_pkg::t_result r_out, n_out;

    logic [MaxS-1:0]  w_match;
    logic             w_found;
    logic [IdxW-1:0]  w_found_idx;
    logic             w_full;
    logic [IdxW-1:0]  w_new_idx;
    logic [IdxW-1:0]  w_samp_row;
    logic [IdxW-1:0]  w_last;
    logic [CntW-1:0]  w_count;
    logic [SumW-1:0]  w_cum_next;
    logic             w_hit;
    logic             w_mem_we;
    logic             w_code_we;
    logic             w_clear;
    logic             w_sum_inc;

    // alphabet lookup
    always_comb begin
        w_found_idx = '0;
        for (int i = 0; i < MaxS; i++) begin
            w_match[i] = (SizeW'(i) < r_learned) && (r_codes[i] == r_cmd.code);
        end
        for (int i = MaxS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found_idx = IdxW'(i);
            end
        end
    end

    assign w_found   = |w_match;
    assign w_full    = (r_learned == SizeW'(MaxS));
    assign w_new_idx = r_learned[IdxW-1:0];
    assign w_last    = IdxW'(r_learned - SizeW'(1));

    always_comb begin
        if (r_cmd.kind == mcts_pkg::K_RESTART) begin
            w_samp_row = '0;
        end else if ({1'b0, r_chain} >= r_learned) begin
            w_samp_row = w_last;
        end else begin
            w_samp_row = r_chain;
        end
    end

    assign w_count    = r_rd_vld ? r_rd_data : '0;
    assign w_cum_next = r_cum + SumW'(w_count);
    assign w_hit      = {w_cum_next, 16'h0000} > r_target;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcts_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = mcts_pkg::S_DECODE;
                end
            end
            mcts_pkg::S_DECODE: begin
                case (r_cmd.kind)
                    mcts_pkg::K_CLEAR: n_state = mcts_pkg::S_IDLE;
                    mcts_pkg::K_TRAIN: begin
                        if (!w_found && w_full) begin
                            n_state = mcts_pkg::S_IDLE;
                        end else if (r_prev_vld) begin
                            n_state = mcts_pkg::S_TRAIN_UPD;
                        end else begin
                            n_state = mcts_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        if (r_learned == '0) begin
                            n_state = mcts_pkg::S_IDLE;
                        end else begin
                            n_state = mcts_pkg::S_WALK;
                        end
                    end
                endcase
            end
            mcts_pkg::S_TRAIN_UPD: n_state = mcts_pkg::S_IDLE;
            mcts_pkg::S_WALK: begin
                if (w_hit || r_col == w_last) begin
                    n_state = mcts_pkg::S_IDLE;
                end
            end
            default: n_state = mcts_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_learned   = r_learned;
        n_prev_idx  = r_prev_idx;
        n_prev_vld  = r_prev_vld;
        n_chain     = r_chain;
        n_row       = r_row;
        n_col       = r_col;
        n_cum       = r_cum;
        n_target    = r_target;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_rd_addr   = {r_row, r_col + IdxW'(1)};
        w_mem_we    = 1'b0;
        w_code_we   = 1'b0;
        w_clear     = 1'b0;
        w_sum_inc   = 1'b0;
        case (r_state)
            mcts_pkg::S_IDLE: begin
                o_q_pop = i_q_valid;
            end
            mcts_pkg::S_DECODE: begin
                case (r_cmd.kind)
                    mcts_pkg::K_CLEAR: begin
                        w_clear     = 1'b1;
                        n_learned   = '0;
                        n_prev_idx  = '0;
                        n_prev_vld  = 1'b0;
                        n_chain     = '0;
                        n_out_valid = 1'b1;
                        n_out       = '0;
                    end
                    mcts_pkg::K_TRAIN: begin
                        if (!w_found && w_full) begin
                            n_prev_vld  = 1'b0;
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.status = mcts_pkg::ST_FULL;
                            n_out.size  = r_learned;
                        end else begin
                            n_row       = r_prev_idx;
                            n_col       = w_found ? w_found_idx : w_new_idx;
                            w_rd_addr   = {r_prev_idx, n_col};
                            n_prev_idx  = n_col;
                            n_prev_vld  = 1'b1;
                            w_code_we   = !w_found;
                            n_learned   = w_found ? r_learned : r_learned + SizeW'(1);
                            n_out.status = mcts_pkg::ST_OK;
                            n_out.index = n_col;
                            n_out.code  = r_cmd.code;
                            n_out.is_new = !w_found;
                            n_out.size  = n_learned;
                            n_out_valid = !r_prev_vld;
                        end
                    end
                    default: begin
                        if (r_learned == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.status = mcts_pkg::ST_NONE;
                        end else begin
                            n_row     = w_samp_row;
                            n_col     = '0;
                            n_cum     = '0;
                            w_rd_addr = {w_samp_row, IdxW'(0)};
                            n_target  = TgtW'(r_cmd.rv) * TgtW'(r_sums[w_samp_row]);
                        end
                    end
                endcase
            end
            mcts_pkg::S_TRAIN_UPD: begin
                if (w_count != mcts_pkg::CountMax) begin
                    w_mem_we  = 1'b1;
                    w_sum_inc = 1'b1;
                end
                n_out_valid = 1'b1;
            end
            mcts_pkg::S_WALK: begin
                n_cum = w_cum_next;
                if (w_hit || r_col == w_last) begin
                    n_chain      = r_col;
                    n_out_valid  = 1'b1;
                    n_out.status = w_hit ? mcts_pkg::ST_OK : mcts_pkg::ST_EMPTY;
                    n_out.index  = r_col;
                    n_out.code   = r_codes[r_col];
                    n_out.is_new = 1'b0;
                    n_out.size   = r_learned;
                end else begin
                    n_col = r_col + IdxW'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcts_pkg::S_IDLE;
            r_learned   <= '0;
            r_prev_idx  <= '0;
            r_prev_vld  <= 1'b0;
            r_chain     <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MaxS; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_learned   <= n_learned;
            r_prev_idx  <= n_prev_idx;
            r_prev_vld  <= n_prev_vld;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
            if (w_clear) begin
                r_vld <= '0;
                for (int i = 0; i < MaxS; i++) begin
                    r_sums[i] <= '0;
                end
            end else begin
                if (w_mem_we) begin
                    r_vld[{r_row, r_col}] <= 1'b1;
                end
                if (w_sum_inc) begin
                    r_sums[r_row] <= r_sums[r_row] + SumW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_cum    <= n_cum;
        r_target <= n_target;
        r_out    <= n_out;
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_code_we) begin
            r_codes[w_new_idx] <= r_cmd.code;
        end
    end

    // transition count store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[{r_row, r_col}] <= w_count + CntW'(1);
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_vld  <= r_vld[w_rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_learned_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_learned <= SizeW'(MaxS))
        else $error("alphabet size beyond capacity");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == mcts_pkg::S_IDLE)
        else $error("result while back end still working");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == mcts_pkg::ST_NONE) |->
            (r_out.index == '0 && r_out.code == '0 && r_learned == '0))
        else $error("no-alphabet result with payload");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != mcts_pkg::ST_NONE && r_learned != '0) |->
            ({1'b0, r_out.index} < r_learned))
        else $error("reported index outside alphabet");

endmodule

/* sv/markov_chain_train_and_sample.sv */
`timescale 1ns / 1ps
// after the queue, the back end pops a transaction in idle and decodes it; clear, sampling
// with no alphabet and a first or dropped training symbol end there, other training adds
// an update step, and sampling walks the columns of its row until the cumulative count
// passes the target or the last column is reached; the back end takes the next transaction
// only when back in idle; a two-entry queue in front, busy when full
// results strobed for one cycle, cannot be stalled; synchronous active-low reset empties model
module markov_chain_train_and_sample (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_symbol_code,
    input  logic [15:0] i_random_value,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_symbol_index,
    output logic [15:0] o_out_code,
    output logic        o_is_new_symbol,
    output logic [4:0]  o_alphabet_size
);

    logic              w_q_valid;
    logic              w_q_pop;
    mcts_pkg::t_cmd    w_q_cmd;
    mcts_pkg::t_result w_result;

    mcts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_symbol_code  (i_symbol_code),
        .i_random_value (i_random_value),
        .o_q_valid      (w_q_valid),
        .o_q_cmd        (w_q_cmd),
        .i_q_pop        (w_q_pop)
    );

    mcts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .o_result  (w_result)
    );

    assign o_status        = w_result.status;
    assign o_symbol_index  = w_result.index;
    assign o_out_code      = w_result.code;
    assign o_is_new_symbol = w_result.is_new;
    assign o_alphabet_size = w_result.size;

endmodule

/* test/tb_markov_chain_train_and_sample.sv */
`timescale 1ns / 1ps
module tb_markov_chain_train_and_sample;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [15:0] code;
        logic        is_new;
        logic [4:0]  size;
    } t_draw;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    class chain_scoreboard;
        logic [15:0] codes[16];
        int unsigned n_learned;
        int unsigned counts[16][16];
        int unsigned sums[16];
        int unsigned prev_idx;
        bit          prev_ok;
        int unsigned chain_pos;
        t_draw       pending[$];

        function void clear_model();
            n_learned = 0;
            foreach (counts[r, c]) counts[r][c] = 0;
            foreach (sums[r]) sums[r] = 0;
            prev_idx = 0;
            prev_ok = 0;
            chain_pos = 0;
        endfunction

        function void wipe();
            foreach (codes[i]) codes[i] = '0;
            clear_model();
        endfunction

        function t_draw draw_from(int unsigned row, logic [15:0] rv);
            t_draw d;
            longint unsigned cum;
            longint unsigned target;
            int unsigned pick;
            bit hit;
            d = '{mcts_pkg::ST_OK, 0, 0, 0, 0};
            cum = 0;
            hit = 0;
            if (n_learned == 0) begin
                d.status = mcts_pkg::ST_NONE;
            end else begin
                if (row >= n_learned) row = n_learned - 1;
                target = longint'(rv) * sums[row];
                pick = n_learned - 1;
                for (int i = 0; i < n_learned; i++) begin
                    cum += counts[row][i];
                    if (!hit && (cum << 16) > target) begin
                        pick = i;
                        hit = 1;
                    end
                end
                if (!hit) d.status = mcts_pkg::ST_EMPTY;
                chain_pos = pick;
                d.index = 4'(pick);
                d.code = codes[pick];
            end
            d.size = 5'(n_learned);
            return d;
        endfunction

        function void note_command(logic [1:0] op, logic [15:0] sym, logic [15:0] rv);
            t_draw d;
            int idx;
            d = '{mcts_pkg::ST_OK, 0, 0, 0, 0};
            case (op)
                mcts_pkg::OP_CLEAR: clear_model();
                mcts_pkg::OP_TRAIN: begin
                    idx = -1;
                    for (int i = 0; i < n_learned; i++)
                        if (idx < 0 && codes[i] == sym) idx = i;
                    if (idx < 0 && n_learned >= 16) begin
                        prev_ok = 0;
                        d.status = mcts_pkg::ST_FULL;
                    end else begin
                        if (idx < 0) begin
                            idx = n_learned;
                            codes[idx] = sym;
                            n_learned++;
                            d.is_new = 1;
                        end
                        if (prev_ok && counts[prev_idx][idx] < 65535) begin
                            counts[prev_idx][idx]++;
                            sums[prev_idx]++;
                        end
                        prev_idx = idx;
                        prev_ok = 1;
                        d.index = 4'(idx);
                        d.code = codes[idx];
                    end
                end
                mcts_pkg::OP_RESTART: d = draw_from(0, rv);
                default: d = draw_from(chain_pos, rv);
            endcase
            d.size = 5'(n_learned);
            pending = {pending, d};
        endfunction

        task check_result(t_draw got);
            t_draw w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report_mismatch("status", got.status, w.status);
            if (got.index !== w.index) report_mismatch("symbol_index", got.index, w.index);
            if (got.code !== w.code) report_mismatch("out_code", got.code, w.code);
            if (got.is_new !== w.is_new) report_mismatch("is_new_symbol", got.is_new, w.is_new);
            if (got.size !== w.size) report_mismatch("alphabet_size", got.size, w.size);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_operation = '0;
    logic [15:0] i_symbol_code = '0;
    logic [15:0] i_random_value = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_symbol_index;
    logic [15:0] o_out_code;
    logic        o_is_new_symbol;
    logic [4:0]  o_alphabet_size;

    chain_scoreboard sb = new();
    bit quiet_tail = 0;
    logic [15:0] vocab[16];

    markov_chain_train_and_sample u_top (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_status, o_symbol_index, o_out_code, o_is_new_symbol,
                              o_alphabet_size});
    end

    task automatic send_command(input logic [1:0] op, input logic [15:0] sym,
                                input logic [15:0] rv);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_operation <= op;
        i_symbol_code <= sym;
        i_random_value <= rv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, sym, rv);
    endtask

    task automatic wait_drained();
        start <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int r;
        logic [15:0] rv;
        sb.wipe();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_command(mcts_pkg::OP_NEXT, 16'hFFFF, 16'hFFFF);
        send_command(mcts_pkg::OP_RESTART, 16'h0000, 16'h0000);
        send_command(mcts_pkg::OP_TRAIN, 16'h0000, 16'h0000);
        send_command(mcts_pkg::OP_RESTART, 16'h0000, 16'h1234);
        send_command(mcts_pkg::OP_TRAIN, 16'hFFFF, 16'h0000);
        send_command(mcts_pkg::OP_TRAIN, 16'h0000, 16'h0000);
        send_command(mcts_pkg::OP_RESTART, 16'h0000, 16'h0000);
        send_command(mcts_pkg::OP_RESTART, 16'h0000, 16'hFFFF);
        send_command(mcts_pkg::OP_NEXT, 16'h0000, 16'h8000);
        for (int i = 0; i < 17; i++)
            send_command(mcts_pkg::OP_TRAIN, 16'(16'h0100 + i), 16'h0000);
        send_command(mcts_pkg::OP_NEXT, 16'h0000, 16'hFFFF);
        send_command(mcts_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
        send_command(mcts_pkg::OP_NEXT, 16'h0000, 16'h0000);
        wait_drained();
        for (int i = 0; i < 16; i++) vocab[i] = 16'($urandom);
        for (int n = 0; n < 1200; n++) begin
            if (n > 1080) quiet_tail = 1;
            if (n == 600) wait_drained();
            r = $urandom_range(0, 99);
            rv = 16'($urandom);
            if (r < 2) send_command(mcts_pkg::OP_CLEAR, 16'($urandom), rv);
            else if (r < 50)
                send_command(mcts_pkg::OP_TRAIN,
                             ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                             vocab[$urandom_range(0, (n % 300 < 150) ? 5 : 15)], rv);
            else if (r < 60) send_command(mcts_pkg::OP_RESTART, 16'($urandom), rv);
            else send_command(mcts_pkg::OP_NEXT, 16'($urandom), rv);
        end
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
